### design/nr_sss_pkg.sv
// shared constants, types and sequence tables for the nr sss sequence mapper
package nr_sss_pkg;

  localparam int SEQ_LEN         = 127;
  localparam int IDX_W           = 7;
  localparam int MAX_SYMBOL_SIZE = 4096;
  localparam int KW              = 14;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 15;

  localparam logic [10:0] SEQ_MAG           = 11'd768;
  localparam logic [14:0] INV_SQRT2_Q15     = 15'd23170;
  localparam logic [5:0]  SSS_CARRIER_START = 6'd56;
  localparam logic [4:0]  SSS_SYMBOL_GAP    = 5'd2;
  localparam logic [9:0]  DIV3_RECIP        = 10'd683;
  localparam logic [6:0]  CEIL_BIAS         = 7'd127;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_CELL_ID           = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AMPLITUDE         = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ANTENNA_PORTS     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CARRIER_OFFSET    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SUBCARRIER_OFFSET = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SYMBOL_SIZE       = 3'd5;

  typedef struct packed {
    logic [5:0] m0;
    logic [6:0] m1;
  } sss_shift_t;

  // m-sequence x(i+7) = x(i+tap) ^ x(i), seeded 1000000
  function automatic logic [SEQ_LEN-1:0] msequence(input int tap);
    logic [SEQ_LEN-1:0] x;
    int i;
    x    = '0;
    x[0] = 1'b1;
    for (i = 0; i < SEQ_LEN - 7; i++) begin
      x[i+7] = x[i+tap] ^ x[i];
    end
    return x;
  endfunction

  localparam logic [SEQ_LEN-1:0] X0_SEQ = msequence(4);
  localparam logic [SEQ_LEN-1:0] X1_SEQ = msequence(1);

  // nid1 = id / 3 by reciprocal, nid2 = id mod 3, then both cyclic shifts
  function automatic sss_shift_t cell_shifts(input logic [9:0] cid);
    logic [19:0] prod;
    logic [8:0]  nid1;
    logic [10:0] three_n1;
    logic [1:0]  nid2;
    logic [1:0]  q;
    sss_shift_t  s;
    prod     = 20'(cid) * 20'(DIV3_RECIP);
    nid1     = prod[19:11];
    three_n1 = 11'({nid1, 1'b0}) + 11'(nid1);
    nid2     = 2'(11'(cid) - three_n1);
    if (nid1 >= 9'd336) begin
      q = 2'd3;
    end else if (nid1 >= 9'd224) begin
      q = 2'd2;
    end else if (nid1 >= 9'd112) begin
      q = 2'd1;
    end else begin
      q = 2'd0;
    end
    s.m0 = 6'(6'({q, 4'b0}) - 6'(q) + 6'({nid2, 2'b0}) + 6'(nid2));
    s.m1 = 7'(nid1 - (9'({q, 7'b0}) - 9'({q, 4'b0})));
    return s;
  endfunction

endpackage

### design/nr_sss_sequence_mapper.sv
// nr secondary synchronisation signal element mapper, top level
//
// Usage: each request on the in_ channel names one element (element_index,
// antenna, start_symbol) and yields exactly one result on the out_ channel:
// the +-768 sequence element, the amplitude-scaled sample, the word index of
// its real part in the antenna grid, the antenna echo and a last flag.
// Handshake: a request moves on an edge with valid high and stall low; the
// receiver drives stall. cfg_ready is always high; the user must write
// registers only while no request is in flight, the block does not enforce it.
// Path: a taken request waits in the input register; its result is then
// registered. Throughput: one request per clock while in_stall is low, set
// by the single input register and result register around the element logic.
// Carrier walk: a 127-entry carrier index table is rebuilt after reset and
// after every write to carrier_offset, subcarrier_offset or symbol_size;
// a start step loads the walk register, then one entry per clock is written
// from the walk register, with in_stall high throughout.
// Stall: while out_stall holds a result, one more request is taken into the
// input register, after which in_stall rises until the result moves.
module nr_sss_sequence_mapper (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [nr_sss_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [nr_sss_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [nr_sss_pkg::IDX_W-1:0]         in_element_index,
  input  logic [2:0]                           in_antenna,
  input  logic [3:0]                           in_start_symbol,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [10:0]                   out_sequence_value,
  output logic signed [10:0]                   out_sample_value,
  output logic [16:0]                          out_grid_index,
  output logic [2:0]                           out_antenna_out,
  output logic                                 out_last_element
);

  localparam int KW    = nr_sss_pkg::KW;
  localparam int IDX_W = nr_sss_pkg::IDX_W;

  // configuration
  logic [9:0]  cell_id_r;
  logic [14:0] amplitude_r;
  logic [3:0]  ports_r;
  logic [11:0] carrier_r;
  logic [11:0] subcarrier_r;
  logic [12:0] symbol_size_r;
  logic        cfg_we;
  logic        geom_write;
  logic [9:0]  cell_id_nxt;
  logic [14:0] amplitude_nxt;
  logic [3:0]  ports_nxt;
  logic [29:0] amp_prod;
  logic [14:0] a_eff_nxt;
  logic [14:0] a_eff_r;
  nr_sss_pkg::sss_shift_t shift_r;

  // carrier table build
  logic            fill_busy_r;
  logic            fill_init_r;
  logic [IDX_W-1:0] fill_cnt_r;
  logic [KW-1:0]   walk_k_r;
  logic [KW-1:0]   walk_k_nxt;
  logic [KW:0]     walk_p1;
  logic [KW-1:0]   k_start;
  logic [12:0]     nsz;
  logic [KW-1:0]   k_mem [nr_sss_pkg::SEQ_LEN];

  // request path
  logic             out_adv;
  logic             in_accept;
  logic [IDX_W-1:0] rd_n;
  logic             s1_valid_r;
  logic [IDX_W-1:0] s1_n_r;
  logic [2:0]       s1_antenna_r;
  logic [3:0]       s1_start_r;
  logic             s1_last_r;
  logic [KW-1:0]    s1_k_r;

  logic [7:0]       i0_sum;
  logic [7:0]       i1_sum;
  logic [IDX_W-1:0] i0;
  logic [IDX_W-1:0] i1;
  logic             negative;
  logic [16:0]      a3;
  logic [16:0]      a3_ceil;
  logic [10:0]      seq_nxt;
  logic [10:0]      samp_nxt;
  logic [4:0]       sym_l;
  logic [17:0]      row_base;
  logic [18:0]      grid_sum;

  logic               out_valid_r;
  logic signed [10:0] out_seq_r;
  logic signed [10:0] out_samp_r;
  logic [16:0]        out_grid_r;
  logic [2:0]         out_antenna_r;
  logic               out_last_r;

  assign cfg_ready  = 1'b1;
  assign cfg_we     = cfg_valid && cfg_ready;
  assign geom_write = cfg_we && ((cfg_index == nr_sss_pkg::CFG_CARRIER_OFFSET) ||
                                 (cfg_index == nr_sss_pkg::CFG_SUBCARRIER_OFFSET) ||
                                 (cfg_index == nr_sss_pkg::CFG_SYMBOL_SIZE));

  assign cell_id_nxt   = (cfg_we && cfg_index == nr_sss_pkg::CFG_CELL_ID) ?
                         cfg_wdata[9:0] : cell_id_r;
  assign amplitude_nxt = (cfg_we && cfg_index == nr_sss_pkg::CFG_AMPLITUDE) ?
                         cfg_wdata[14:0] : amplitude_r;
  assign ports_nxt     = (cfg_we && cfg_index == nr_sss_pkg::CFG_ANTENNA_PORTS) ?
                         cfg_wdata[3:0] : ports_r;
  assign amp_prod      = 30'(amplitude_nxt) * 30'(nr_sss_pkg::INV_SQRT2_Q15);
  assign a_eff_nxt     = (ports_nxt == 4'd1) ? amplitude_nxt : amp_prod[29:15];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_id_r     <= '0;
      amplitude_r   <= 15'd16384;
      ports_r       <= 4'd1;
      carrier_r     <= '0;
      subcarrier_r  <= '0;
      symbol_size_r <= 13'd2048;
      a_eff_r       <= 15'd16384;
      shift_r       <= '0;
    end else begin
      cell_id_r   <= cell_id_nxt;
      amplitude_r <= amplitude_nxt;
      ports_r     <= ports_nxt;
      a_eff_r     <= a_eff_nxt;
      shift_r     <= nr_sss_pkg::cell_shifts(cell_id_nxt);
      if (cfg_we) begin
        case (cfg_index)
          nr_sss_pkg::CFG_CARRIER_OFFSET:    carrier_r     <= cfg_wdata[11:0];
          nr_sss_pkg::CFG_SUBCARRIER_OFFSET: subcarrier_r  <= cfg_wdata[11:0];
          nr_sss_pkg::CFG_SYMBOL_SIZE:       symbol_size_r <= cfg_wdata[12:0];
          default: ;
        endcase
      end
    end
  end

  assign nsz = (symbol_size_r > 13'(nr_sss_pkg::MAX_SYMBOL_SIZE)) ?
               13'(nr_sss_pkg::MAX_SYMBOL_SIZE) : symbol_size_r;
  assign k_start = KW'(carrier_r) + KW'(subcarrier_r) +
                   KW'(nr_sss_pkg::SSS_CARRIER_START);

  // one carrier advance, with the dc skip on wrap
  assign walk_p1    = (KW+1)'(walk_k_r) + (KW+1)'(1);
  assign walk_k_nxt = (walk_p1 >= (KW+1)'(nsz)) ?
                      KW'(walk_p1 + (KW+1)'(1) - (KW+1)'(nsz)) : KW'(walk_p1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_busy_r <= 1'b1;
      fill_init_r <= 1'b1;
      fill_cnt_r  <= '0;
    end else if (geom_write) begin
      fill_busy_r <= 1'b1;
      fill_init_r <= 1'b1;
      fill_cnt_r  <= '0;
    end else if (fill_busy_r) begin
      if (fill_init_r) begin
        fill_init_r <= 1'b0;
        walk_k_r    <= k_start;
      end else begin
        walk_k_r   <= walk_k_nxt;
        fill_cnt_r <= fill_cnt_r + IDX_W'(1);
        if (fill_cnt_r == IDX_W'(nr_sss_pkg::SEQ_LEN - 1)) begin
          fill_busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fill_busy_r && !fill_init_r) begin
      k_mem[fill_cnt_r] <= walk_k_r;
    end
  end

  // request handshake
  assign out_adv   = !out_valid_r || !out_stall;
  assign in_stall  = fill_busy_r || (s1_valid_r && !out_adv);
  assign in_accept = in_valid && !in_stall;
  assign rd_n      = (in_element_index == IDX_W'(nr_sss_pkg::SEQ_LEN)) ?
                     '0 : in_element_index;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (out_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_n_r       <= rd_n;
      s1_antenna_r <= in_antenna;
      s1_start_r   <= in_start_symbol;
      s1_last_r    <= (in_element_index == IDX_W'(nr_sss_pkg::SEQ_LEN - 1));
      s1_k_r       <= k_mem[rd_n];
    end
  end

  // sequence element
  assign i0_sum   = 8'(s1_n_r) + 8'(shift_r.m0);
  assign i1_sum   = 8'(s1_n_r) + 8'(shift_r.m1);
  assign i0       = (i0_sum >= 8'(nr_sss_pkg::SEQ_LEN)) ?
                    IDX_W'(i0_sum - 8'(nr_sss_pkg::SEQ_LEN)) : IDX_W'(i0_sum);
  assign i1       = (i1_sum >= 8'(nr_sss_pkg::SEQ_LEN)) ?
                    IDX_W'(i1_sum - 8'(nr_sss_pkg::SEQ_LEN)) : IDX_W'(i1_sum);
  assign negative = nr_sss_pkg::X0_SEQ[i0] ^ nr_sss_pkg::X1_SEQ[i1];

  // a * 768 >> 15 is a * 3 >> 7; the negative side rounds towards minus infinity
  assign a3       = 17'({a_eff_r, 1'b0}) + 17'(a_eff_r);
  assign a3_ceil  = a3 + 17'(nr_sss_pkg::CEIL_BIAS);
  assign seq_nxt  = negative ? 11'(11'd0 - nr_sss_pkg::SEQ_MAG) : nr_sss_pkg::SEQ_MAG;
  assign samp_nxt = negative ? 11'(11'd0 - {1'b0, a3_ceil[16:7]}) : {1'b0, a3[16:7]};

  // grid word index
  assign sym_l    = 5'(s1_start_r) + nr_sss_pkg::SSS_SYMBOL_GAP;
  assign row_base = 18'(sym_l) * 18'(nsz);
  assign grid_sum = 19'(row_base) + 19'(s1_k_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && s1_valid_r) begin
      out_seq_r     <= $signed(seq_nxt);
      out_samp_r    <= $signed(samp_nxt);
      out_grid_r    <= {grid_sum[15:0], 1'b0};
      out_antenna_r <= s1_antenna_r;
      out_last_r    <= s1_last_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_sequence_value = out_seq_r;
  assign out_sample_value   = out_samp_r;
  assign out_grid_index     = out_grid_r;
  assign out_antenna_out    = out_antenna_r;
  assign out_last_element   = out_last_r;

  // sample sign follows the sequence sign
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_seq_r == 11'sd768 && !out_samp_r[10]) ||
                     (out_seq_r == -11'sd768 && (out_samp_r[10] || out_samp_r == 11'sd0))))
    else $error("sample sign disagrees with sequence element");

  assert property (@(posedge clk) disable iff (!rst_n)
    geom_write |=> (fill_busy_r && fill_init_r && fill_cnt_r == '0))
    else $error("carrier table rebuild not restarted after geometry write");

  assert property (@(posedge clk) disable iff (!rst_n)
    (fill_busy_r && !fill_init_r && !geom_write &&
     fill_cnt_r == IDX_W'(nr_sss_pkg::SEQ_LEN - 1)) |=> !fill_busy_r)
    else $error("carrier table rebuild did not finish after last entry");

  assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_element_index == IDX_W'(nr_sss_pkg::SEQ_LEN - 1))
      |=> (s1_valid_r && s1_last_r && s1_n_r == IDX_W'(nr_sss_pkg::SEQ_LEN - 1)))
    else $error("last element request lost its flag");

endmodule
